// ===== rtl/bbtm_pkg.sv =====
package bbtm_pkg;
  localparam int SLOTS_DEF = 64;
  localparam int ID_BITS_DEF = 32;
  localparam int SLOT_W = 6;
  localparam int WBID_W = 32;
  localparam int IN_ID_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MOD, ST_APPLY, ST_OUT
  } state_t;

  // scan results handed along the cell chain
  typedef struct packed {
    logic hit;
    logic empty;
  } scan_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    lfsr_step = {v[0] ^ v[2] ^ v[3] ^ v[5], v[15:1]};
  endfunction
endpackage

// ===== rtl/bbtm_if.sv =====
interface bbtm_req_if;
  import bbtm_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [IN_ID_W-1:0] block_id;
  logic modify;
  modport source(output valid, operation, block_id, modify, input ready);
  modport sink(input valid, operation, block_id, modify, output ready);
endinterface

interface bbtm_rsp_if;
  import bbtm_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  logic [SLOT_W-1:0] slot;
  logic fetch_needed;
  logic writeback_needed;
  logic [WBID_W-1:0] writeback_id;
  modport source(output valid, hit, slot, fetch_needed, writeback_needed, writeback_id,
                 input ready);
  modport sink(input valid, hit, slot, fetch_needed, writeback_needed, writeback_id,
               output ready);
endinterface

// ===== rtl/block_buffer_tag_manager.sv =====
// Steps after a request word is accepted: scan, modulo check, apply, then the
// result word is held until taken; an eviction runs a shift-subtract modulo.
// One request in flight: no new request word is accepted until the result word
// has been taken, so an output stall also holds off the next request.
// Reset (sync, active high) clears all tags and dirty bits, count to zero,
// slots_in_use to 64, seed and LFSR to 1.
module block_buffer_tag_manager
  import bbtm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  bbtm_req_if.sink             req,
  bbtm_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  localparam int SW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);
  localparam int DW = 16 + NW;

  state_t state, state_next;
  logic [6:0] slots_in_use;
  logic [15:0] lfsr;
  logic [NW-1:0] occ;
  logic [1:0] op;
  logic [ID_BITS-1:0] key;
  logic mod;
  logic [NW-1:0] n;
  logic [15:0] rem;
  logic [SW-1:0] place;
  logic found, has_empty;
  logic [SW-1:0] hit_idx, emp_idx;
  logic r_hit, r_fetch, r_wb;
  logic [SW-1:0] r_slot;
  logic [WBID_W-1:0] r_wbid;

  logic [ID_BITS-1:0] tags [SLOTS];
  logic dirt [SLOTS];
  logic cell_hit [SLOTS];
  logic cell_emp [SLOTS];
  scan_t chain [SLOTS+1];
  logic wr_en [SLOTS];
  logic do_write, write_clear, write_dirty_only, write_dirty;

  always_comb begin
    if (slots_in_use == 7'd0) n = NW'(1);
    else if (32'(slots_in_use) > SLOTS) n = NW'(SLOTS);
    else n = NW'(slots_in_use);
  end

  assign chain[0] = '0;
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    bbtm_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk, .rst, .key, .active(32'(i) < 32'(n)),
      .scan_in(chain[i]), .scan_out(chain[i+1]),
      .wr(wr_en[i]), .wr_clear(write_clear), .wr_dirty_only(write_dirty_only),
      .wr_tag(key), .wr_dirty(write_dirty),
      .tag(tags[i]), .dirty(dirt[i]), .is_hit(cell_hit[i]), .is_empty(cell_emp[i])
    );
    assign wr_en[i] = do_write && place == SW'(i);
  end

  // first hit / first empty: one-hot-ish priority, registered during SCAN
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      found <= chain[SLOTS].hit;
      has_empty <= chain[SLOTS].empty;
      hit_idx <= '0;
      emp_idx <= '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (cell_hit[i]) hit_idx <= SW'(i);
        if (cell_emp[i]) emp_idx <= SW'(i);
      end
    end
  end

  logic zero_op;
  assign zero_op = op == OP_UNUSED || key == '0;
  logic need_victim;
  assign need_victim = !zero_op && op != OP_DELETE && !found && !has_empty;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req.valid) state_next = ST_SCAN;
      ST_SCAN: state_next = ST_MOD;
      ST_MOD:  if (!need_victim || rem < 16'(n)) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_OUT;
      ST_OUT: if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    do_write = 1'b0;
    write_clear = 1'b0;
    write_dirty_only = 1'b0;
    write_dirty = (op == OP_STORE) ? mod : 1'b0;
    place = need_victim ? rem[SW-1:0] : (found ? hit_idx : emp_idx);
    if (state == ST_APPLY && !zero_op) begin
      if (op == OP_DELETE) begin
        do_write = found;
        write_clear = 1'b1;
      end else if (found) begin
        do_write = op == OP_STORE;
        write_dirty_only = 1'b1;
      end else begin
        do_write = 1'b1;
      end
    end
  end

  assign req.ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op <= req.operation;
      key <= ID_BITS'(req.block_id);
      mod <= req.modify;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= 7'd64;
      lfsr <= 16'd1;
      occ <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_SLOTS) slots_in_use <= cfg_data[6:0];
      if (cfg_we && cfg_index == REG_SEED)
        lfsr <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
      if (state == ST_SCAN && !(zero_op || op == OP_DELETE || chain[SLOTS].hit)
          && !chain[SLOTS].empty)
        lfsr <= lfsr_step(lfsr);
      if (state == ST_APPLY && !zero_op) begin
        if (op == OP_DELETE && found && occ != '0) occ <= occ - NW'(1);
        else if (op != OP_DELETE && !found && has_empty && 32'(occ) < SLOTS)
          occ <= occ + NW'(1);
      end
    end
  end

  // modulo by subtract-shift: rem starts at stepped lfsr
  logic [3:0] sh;
  logic [DW-1:0] dvs;
  assign dvs = DW'(n) << sh;
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      rem <= lfsr_step(lfsr);
      sh <= 4'd15;
    end else if (state == ST_MOD) begin
      if (DW'(rem) >= dvs) rem <= rem - dvs[15:0];
      if (sh != 4'd0) sh <= sh - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_APPLY) begin
      r_hit <= !zero_op && found;
      r_slot <= zero_op || (op == OP_DELETE && !found) ? '0 : place;
      r_fetch <= !zero_op && op == OP_READ && !found;
      r_wb <= need_victim && dirt[place];
      r_wbid <= (need_victim && dirt[place]) ? WBID_W'(tags[place]) : '0;
    end
  end

  assign rsp.valid = state == ST_OUT;
  assign rsp.hit = r_hit;
  assign rsp.slot = SLOT_W'(r_slot);
  assign rsp.fetch_needed = r_fetch;
  assign rsp.writeback_needed = r_wb;
  assign rsp.writeback_id = r_wbid;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid) else $error("ready while result pending");
  a_fetch_nohit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.fetch_needed)) else $error("hit and fetch");
  a_wb_nohit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.writeback_needed |-> !rsp.hit) else $error("writeback on hit");
  a_occ: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= SLOTS) else $error("count overflow");
`endif
endmodule

// ===== rtl/bbtm_cell.sv =====
module bbtm_cell
  import bbtm_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ID_BITS-1:0] key,
  input  logic               active,
  input  scan_t              scan_in,
  output scan_t              scan_out,
  input  logic               wr,
  input  logic               wr_clear,
  input  logic               wr_dirty_only,
  input  logic [ID_BITS-1:0] wr_tag,
  input  logic               wr_dirty,
  output logic [ID_BITS-1:0] tag,
  output logic               dirty,
  output logic               is_hit,
  output logic               is_empty
);
  assign is_hit = active && tag == key;
  assign is_empty = active && tag == '0;
  // priority chain: hit/empty found earlier passes through
  assign scan_out.hit = scan_in.hit | is_hit;
  assign scan_out.empty = scan_in.empty | is_empty;
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
      dirty <= 1'b0;
    end else if (wr) begin
      if (wr_clear) begin
        tag <= '0;
        dirty <= 1'b0;
      end else begin
        if (!wr_dirty_only) tag <= wr_tag;
        dirty <= wr_dirty;
      end
    end
  end
endmodule
